>>> rtl/tps_pkg.sv
package tps_pkg;

    // request kind codes on the input channel
    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_FADE = 2'd2;

    localparam logic [7:0]  FADE_SCALE_RST = 8'd224;
    localparam logic [31:0] EVEN_MASK      = 32'h00FF00FF;
    localparam logic [31:0] ODD_MASK       = 32'hFF00FF00;

    // classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_ADD,
        OP_FADE
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_FADE,
        S_FDONE
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] value;
    } t_req;

    // back end to queue
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_q_ctl;

    // scale each byte by s/256; s < 256 so no byte spills into its neighbor
    function automatic logic [31:0] scale_pixel(input logic [31:0] p, input logic [7:0] s);
        logic [31:0] even;
        logic [31:0] odd;
        even = (p & EVEN_MASK) * {24'd0, s};
        odd  = ((p & ODD_MASK) >> 8) * {24'd0, s};
        return ((even & ODD_MASK) >> 8) | (odd & ODD_MASK);
    endfunction

endpackage

>>> rtl/trail_pixel_store_with_fade_top.sv
// Pixel store of SIDE x SIDE 32-bit words with additive deposit and byte-wise fade.
// A read/deposit request passes S_IDLE (pop, RAM read) and S_ACCESS (write-back, result
// register load); a fade passes S_FADE (sweep) and S_FDONE (result register load).
// The back end takes no new request until the read-modify-write on the single-write RAM is done;
// a fade holds the back end for the whole sweep, one word per cycle.
// Reset (i_rst_n low, synchronous): fade scale returns to 224, then a clearing pass writes zero
// to all SIDE*SIDE words while o_in_ready stays low.
module trail_pixel_store_with_fade_top #(
    parameter int SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: fade scale
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_x,
    input  logic [7:0]  i_y,
    input  logic [31:0] i_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_pixel
);
    import tps_pkg::*;

    // word address width of the store
    localparam int CW = $clog2(SIDE * SIDE);

    t_q_ctl        ctl;
    logic          head_valid;
    t_req          head;
    logic [CW-1:0] head_addr;

    // Front end: range check, address linearization, kind decode and a two-entry
    // queue; it keeps taking requests while the back end is busy, until the queue is full.
    tps_front #(
        .SIDE (SIDE),
        .CW   (CW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_value      (i_value),
        .i_ctl        (ctl),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_head_addr  (head_addr)
    );

    // Back end: clearing pass, read / read-modify-write on the store, fade sweep,
    // and the result register that decouples the output side.
    tps_back #(
        .SIDE (SIDE),
        .CW   (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_head_addr  (head_addr),
        .o_ctl        (ctl),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel      (o_pixel)
    );

endmodule

>>> rtl/tps_ram.sv
module tps_ram #(
    parameter int W = 32,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tps_front.sv
module tps_front #(
    parameter int SIDE = 64,
    parameter int CW   = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_kind,
    input  logic [7:0]      i_x,
    input  logic [7:0]      i_y,
    input  logic [31:0]     i_value,
    input  tps_pkg::t_q_ctl i_ctl,
    output logic            o_head_valid,
    output tps_pkg::t_req   o_head,
    output logic [CW-1:0]   o_head_addr
);
    import tps_pkg::*;

    logic        in_range;
    logic [15:0] lin;
    t_req        req;
    logic        push;

    t_req          r_q_req  [2];
    logic [CW-1:0] r_q_addr [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign in_range = ({1'b0, i_x} < 9'(SIDE)) && ({1'b0, i_y} < 9'(SIDE));
    assign lin      = 16'(i_y) * 16'(SIDE) + 16'(i_x);

    always_comb begin
        req.value = i_value;
        unique case (i_kind)
            KIND_READ: req.op = in_range ? OP_READ : OP_NONE;
            KIND_ADD:  req.op = in_range ? OP_ADD : OP_NONE;
            KIND_FADE: req.op = OP_FADE;
            default:   req.op = OP_NONE;
        endcase
    end

    assign o_in_ready   = !i_ctl.clearing && (r_cnt != 2'd2);
    assign push         = i_in_valid && o_in_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q_req[r_rp];
    assign o_head_addr  = r_q_addr[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_req[r_wp]  <= req;
            r_q_addr[r_wp] <= lin[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_ctl.pop) begin
                r_rp <= !r_rp;
            end
            if (push && !i_ctl.pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_ctl.pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> rtl/tps_back.sv
module tps_back #(
    parameter int SIDE = 64,
    parameter int CW   = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_head_valid,
    input  tps_pkg::t_req   i_head,
    input  logic [CW-1:0]   i_head_addr,
    output tps_pkg::t_q_ctl o_ctl,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_pixel
);
    import tps_pkg::*;

    localparam int            CELLS = SIDE * SIDE;
    localparam logic [CW-1:0] LAST  = CW'(CELLS - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_fv;
    logic [CW-1:0] r_waddr;
    t_op           r_op;
    logic [CW-1:0] r_addr;
    logic [31:0]   r_value;
    logic [7:0]    r_scale;
    logic          r_out_valid;
    logic [31:0]   r_pixel;

    logic          out_free;
    logic          pop;
    logic          re, we;
    logic [CW-1:0] raddr, waddr;
    logic [31:0]   wdata, rdata;
    logic          res_load;
    logic [31:0]   res_val;

    assign out_free = !r_out_valid || i_out_ready;

    tps_ram #(
        .W (32),
        .D (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.op)
                        OP_READ, OP_ADD: n_state = S_ACCESS;
                        OP_FADE:         n_state = S_FADE;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_ACCESS: if (out_free) n_state = S_IDLE;
            S_FADE:   if (r_cnt == LAST) n_state = S_FDONE;
            S_FDONE:  if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop      = 1'b0;
        re       = 1'b0;
        raddr    = i_head_addr;
        we       = 1'b0;
        waddr    = r_addr;
        wdata    = rdata + r_value;
        res_load = 1'b0;
        res_val  = 32'd0;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = 32'd0;
            end
            S_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.op)
                        OP_READ, OP_ADD: begin
                            pop = 1'b1;
                            re  = 1'b1;
                        end
                        OP_FADE: pop = 1'b1;
                        default: begin
                            pop      = out_free;
                            res_load = out_free;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                if (out_free) begin
                    res_load = 1'b1;
                    res_val  = (r_op == OP_READ) ? rdata : 32'd0;
                    we       = (r_op == OP_ADD);
                end
            end
            S_FADE: begin
                re    = 1'b1;
                raddr = r_cnt;
                we    = r_fv;
                waddr = r_waddr;
                wdata = scale_pixel(rdata, r_scale);
            end
            S_FDONE: begin
                // last write of the sweep drains here
                we       = r_fv;
                waddr    = r_waddr;
                wdata    = scale_pixel(rdata, r_scale);
                res_load = out_free;
            end
            default: ;
        endcase
    end

    assign o_ctl.pop      = pop;
    assign o_ctl.clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_fv        <= 1'b0;
            r_scale     <= FADE_SCALE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fv    <= (r_state == S_FADE);
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if ((r_state == S_CLEAR) || (r_state == S_FADE)) begin
                r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= r_cnt;
        if (pop) begin
            r_op    <= i_head.op;
            r_addr  <= i_head_addr;
            r_value <= i_head.value;
        end
        if (res_load) begin
            r_pixel <= res_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_pixel;

endmodule

>>> sim/tb_top.sv
module tb_top;
    import tps_pkg::*;

    localparam int SIDE = 64;
    localparam int CELLS = SIDE * SIDE;
    // kind 3 has no name in the package; the block must treat it as a no-op
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // generous ceiling for the whole run
    localparam int TIMEOUT_CYCLES = 2_000_000;
    // quiet cycles after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  req_kind = KIND_READ;
    logic [7:0]  req_x = '0;
    logic [7:0]  req_y = '0;
    logic [31:0] req_value = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] res_pixel;

    // local copy of the store and the fade scale, advanced at request acceptance
    logic [31:0] pixel_model [CELLS];
    logic [7:0]  scale_model = FADE_SCALE_RST;
    // pixel value owed for each accepted request, oldest first
    logic [31:0] owed_pixels [$];

    // per-cycle chance (percent) that the sender idles / the receiver stalls
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int n_errors = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_fades = 0;
    int n_live_reads = 0;

    trail_pixel_store_with_fade_top #(
        .SIDE(SIDE)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_kind      (req_kind),
        .i_x         (req_x),
        .i_y         (req_y),
        .i_value     (req_value),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_pixel     (res_pixel)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // each byte times s, keep the high byte of the 16-bit product
    function automatic logic [31:0] dim_pixel(input logic [31:0] p, input logic [7:0] s);
        logic [31:0] r;
        logic [15:0] prod;
        for (int b = 0; b < 4; b++) begin
            prod = 16'(p[8*b +: 8]) * 16'(s);
            r[8*b +: 8] = prod[15:8];
        end
        return r;
    endfunction

    // applies one request to the local store and returns the pixel it yields
    function automatic logic [31:0] apply_request(input logic [1:0] k, input logic [7:0] cx,
                                                  input logic [7:0] cy, input logic [31:0] v);
        logic        hit;
        int          idx;
        logic [31:0] pix;
        hit = (cx < SIDE) && (cy < SIDE);
        idx = int'(cy) * SIDE + int'(cx);
        pix = '0;
        case (k)
            KIND_READ: begin
                if (hit) pix = pixel_model[idx];
            end
            KIND_ADD: begin
                if (hit) pixel_model[idx] = pixel_model[idx] + v;
            end
            KIND_FADE: begin
                // zero pixels stay zero; dim_pixel(0) is 0 anyway
                for (int i = 0; i < CELLS; i++)
                    if (pixel_model[i] != 0)
                        pixel_model[i] = dim_pixel(pixel_model[i], scale_model);
            end
            default: ; // spare kind: nothing happens, pixel 0
        endcase
        return pix;
    endfunction

    // ---------------------------------------------------------------
    // Result checker and receiver back-pressure
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            n_results++;
            if (owed_pixels.size() == 0) begin
                $error("pixel: result %h with no request outstanding", res_pixel);
                n_errors++;
            end else begin
                logic [31:0] want;
                want = owed_pixels.pop_front();
                if (res_pixel !== want) begin
                    $error("pixel mismatch: expected %h, actual %h", want, res_pixel);
                    n_errors++;
                end
            end
        end
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------

    // one request; valid is left high on return so back-to-back requests
    // do not drop valid between them unless the sender idles
    task automatic send_req(input logic [1:0] k, input logic [7:0] cx, input logic [7:0] cy,
                            input logic [31:0] v);
        logic [31:0] owed;
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req_kind  <= k;
        req_x     <= cx;
        req_y     <= cy;
        req_value <= v;
        do @(posedge clk); while (!req_ready);
        owed = apply_request(k, cx, cy, v);
        owed_pixels.insert(owed_pixels.size(), owed);
        n_sent++;
        if (k == KIND_FADE) n_fades++;
        if (k == KIND_READ && owed != 0) n_live_reads++;
    endtask

    // drop valid and hold off until every owed result is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (owed_pixels.size() != 0) @(posedge clk);
    endtask

    // register writes only with the block quiet; a fade sweep finishes
    // before its result, so a short settle covers the tail
    task automatic write_fade_scale(input logic [7:0] s);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        scale_model = s;
    endtask

    // random request biased toward a few corner pixels so reads and fades
    // land on live data; some traffic goes out of range or uses the spare kind
    task automatic send_random_req();
        logic [1:0]  k;
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 3) k = KIND_FADE;
        else if (pick < 7) k = KIND_SPARE;
        else if (pick < 50) k = KIND_ADD;
        else k = KIND_READ;
        pick = $urandom_range(99);
        if (pick < 60) begin
            cx = $urandom_range(1) ? 8'($urandom_range(3)) : 8'(SIDE - 4 + $urandom_range(3));
            cy = $urandom_range(1) ? 8'($urandom_range(3)) : 8'(SIDE - 4 + $urandom_range(3));
        end else if (pick < 85) begin
            cx = 8'($urandom_range(SIDE - 1));
            cy = 8'($urandom_range(SIDE - 1));
        end else begin
            cx = 8'($urandom_range(255));
            cy = 8'($urandom_range(255));
        end
        v = $urandom();
        if ($urandom_range(3) == 0) v = $urandom_range(255) << (8 * $urandom_range(3));
        send_req(k, cx, cy, v);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // cleared store, wraparound, range edges, spare kind, fade at reset scale
    task automatic test_directed();
        send_req(KIND_READ, 8'd0, 8'd0, 32'h0);
        send_req(KIND_READ, 8'(SIDE - 1), 8'(SIDE - 1), 32'hFFFF_FFFF);
        send_req(KIND_ADD, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_req(KIND_ADD, 8'd0, 8'd0, 32'h0000_0001);   // wraps to zero
        send_req(KIND_READ, 8'd0, 8'd0, 32'h0);
        send_req(KIND_ADD, 8'(SIDE - 1), 8'(SIDE - 1), 32'h80FF_4001);
        send_req(KIND_READ, 8'(SIDE - 1), 8'(SIDE - 1), 32'h0);
        // out-of-range deposits must be dropped
        send_req(KIND_ADD, 8'(SIDE), 8'd0, 32'h1234_5678);
        send_req(KIND_ADD, 8'd0, 8'(SIDE), 32'h1234_5678);
        send_req(KIND_ADD, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_req(KIND_READ, 8'(SIDE), 8'd0, 32'h0);
        send_req(KIND_READ, 8'd0, 8'd255, 32'h0);
        send_req(KIND_READ, 8'd255, 8'd255, 32'h0);
        // spare kind touches nothing
        send_req(KIND_SPARE, 8'(SIDE - 1), 8'(SIDE - 1), 32'hFFFF_FFFF);
        send_req(KIND_READ, 8'(SIDE - 1), 8'(SIDE - 1), 32'h0);
        send_req(KIND_ADD, 8'd1, 8'd0, 32'hFFFF_FFFF);
        send_req(KIND_FADE, 8'd0, 8'd0, 32'h0);
        send_req(KIND_READ, 8'd1, 8'd0, 32'h0);
        send_req(KIND_READ, 8'(SIDE - 1), 8'(SIDE - 1), 32'h0);
        send_req(KIND_READ, 8'd5, 8'd5, 32'h0);        // zero stays zero
    endtask

    // fade at the largest and smallest scale
    task automatic test_fade_extremes();
        write_fade_scale(8'd255);
        send_req(KIND_ADD, 8'd2, 8'd2, 32'hFF01_80FE);
        send_req(KIND_FADE, 8'd0, 8'd0, 32'h0);
        send_req(KIND_READ, 8'd2, 8'd2, 32'h0);
        write_fade_scale(8'd0);
        send_req(KIND_FADE, 8'd0, 8'd0, 32'h0);
        send_req(KIND_READ, 8'd2, 8'd2, 32'h0);
        send_req(KIND_READ, 8'(SIDE - 1), 8'(SIDE - 1), 32'h0);
    endtask

    task automatic test_random_phase(input int n, input logic [7:0] s, input int idle_pct,
                                     input int stall_pct, input bool_pause);
        write_fade_scale(s);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            // halfway through, hold the sender off until the pipe has drained, then carry on
            if (bool_pause && i == n / 2) wait_drained();
            send_random_req();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        foreach (pixel_model[i]) pixel_model[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // first request waits out the clearing pass on the ready handshake
        test_directed();
        test_fade_extremes();
        test_random_phase(210, 8'd128, 0, 0, 1'b0);
        test_random_phase(210, 8'd1, 79, 0, 1'b1);
        test_random_phase(210, 8'($urandom_range(255)), 0, 79, 1'b0);
        test_random_phase(210, 8'd200, 28, 28, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d requests (%0d fades), %0d results, %0d reads of live pixels",
                 n_sent, n_fades, n_results, n_live_reads);
        $display("fade scales 224, 255, 0, 1, 128, 200 and one random; idle and stall mixes");
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(4 * TIMEOUT_CYCLES);
        $display("timeout with %0d results outstanding", owed_pixels.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/tps_pkg.sv
rtl/tps_ram.sv
rtl/tps_front.sv
rtl/tps_back.sv
rtl/trail_pixel_store_with_fade_top.sv
sim/tb_top.sv
